### src/prmh_pkg.sv
// shared types, constants, microcode table and bit functions for the
// popcount-rotate-multiply hash core; no dependencies
package prmh_pkg;

  localparam int LANE_COUNT = 8;

  typedef logic [2:0] lane_idx_t;
  typedef logic [6:0] pc_t;

  // lane start values, lane 0 first
  localparam logic [63:0] START_LANES [LANE_COUNT] = '{
    64'h5F62C0DECB051668, 64'hD0BE70F475039C26,
    64'h0A28494D0470FBCF, 64'h2269E48CA777A798,
    64'h0C6771D8D076FAED, 64'hE697EB07151FA162,
    64'h7ED6D2C445D9F5F6, 64'h47DF9C8E1A35F1BA
  };

  // chunk kinds and digest modes
  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] MODE_256  = 2'd0;
  localparam logic [1:0] MODE_128  = 2'd1;

  // microcode fields
  typedef enum logic [2:0] {
    X_HOLD, X_LOAD_IN, X_LOAD_MIX, X_ADD_A, X_ROT
  } x_op_t;

  typedef enum logic [1:0] {
    Y_HOLD, Y_A, Y_B, Y_AB
  } y_op_t;

  typedef enum logic {
    OUT_R, OUT_X
  } out_src_t;

  typedef enum logic [2:0] {
    W_NONE, W_IN, W_MUL, W_MUL_OUT, W_OUT
  } wait_t;

  typedef enum logic [2:0] {
    J_NEXT, J_GOTO, J_NODATA, J_NO_EOM, J_MODE0, J_MODE1, J_DIG
  } jump_t;

  typedef struct packed {
    logic      rd_a_en;
    lane_idx_t rd_a_addr;
    logic      rd_b_en;
    lane_idx_t rd_b_addr;
    x_op_t     x_op;
    y_op_t     y_op;
    logic      mul_start;
    logic      lane_we;
    lane_idx_t lane_waddr;
    logic      mix_we;
    logic      clear;
    logic      set_dig;
    logic      emit;
    out_src_t  out_src;
    logic [1:0] out_num;
    logic      out_last;
    wait_t     wait_sel;
    jump_t     jmp_sel;
    pc_t       target;
  } ucode_t;

  // status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic in_no_data;
    logic in_eom;
    logic mul_busy;
    logic out_blocked;
    logic mode_256;
    logic mode_128;
  } seq_status_t;

  // program layout
  localparam pc_t PC_ENTRY  = 7'd0;
  localparam pc_t PC_CHAIN  = 7'd1;
  localparam pc_t PC_ABSORB = 7'd16;
  localparam pc_t PC_POST   = 7'd48;
  localparam pc_t PC_DIG0   = 7'd49;
  localparam pc_t PC_DIG1   = 7'd50;
  localparam pc_t PC_M2     = 7'd51;
  localparam pc_t PC_M0     = 7'd52;
  localparam pc_t PC_M1     = 7'd68;
  localparam pc_t PC_EMIT2  = 7'd76;

  // population count: per-byte counts, then a sum of eight
  function automatic logic [6:0] ones_in(logic [63:0] v);
    logic [3:0] byte_cnt [8];
    logic [6:0] total;
    for (int b = 0; b < 8; b++) begin
      byte_cnt[b] = 4'd0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(v[b*8+i]);
      end
    end
    total = 7'd0;
    for (int b = 0; b < 8; b++) begin
      total = total + 7'(byte_cnt[b]);
    end
    return total;
  endfunction

  // rotate right by own popcount; a count of 0 or 64 leaves v as is
  function automatic logic [63:0] rot_by_ones(logic [63:0] v);
    logic [6:0]   r;
    logic [127:0] dbl;
    r   = ones_in(v);
    dbl = {v, v} >> r[5:0];
    return dbl[63:0];
  endfunction

  // microcode table, one control word per step
  function automatic ucode_t ucode(pc_t pc);
    ucode_t     u;
    pc_t        rel;
    lane_idx_t  j;
    logic [1:0] k;
    u          = '0;
    u.x_op     = X_HOLD;
    u.y_op     = Y_HOLD;
    u.out_src  = OUT_R;
    u.wait_sel = W_NONE;
    u.jmp_sel  = J_NEXT;
    u.target   = PC_ENTRY;
    rel        = '0;
    j          = '0;
    k          = '0;
    priority if (pc == PC_ENTRY) begin
      // take a chunk, prefetch lane 0
      u.wait_sel  = W_IN;
      u.x_op      = X_LOAD_IN;
      u.rd_a_en   = 1'b1;
      u.rd_a_addr = 3'd0;
    end else if (pc < PC_ABSORB) begin
      // add lane, rotate by popcount; lane 7 added last
      rel = pc - PC_CHAIN;
      if (!rel[0]) begin
        u.x_op = X_ADD_A;
        if (rel < 7'd14) begin
          u.rd_a_en   = 1'b1;
          u.rd_a_addr = lane_idx_t'(rel[3:1] + 3'd1);
        end
      end else begin
        u.x_op = X_ROT;
      end
      if (rel == 7'd0) begin
        u.jmp_sel = J_NODATA;
        u.target  = PC_POST;
      end else if (rel == 7'd14) begin
        u.jmp_sel = J_DIG;
        u.target  = PC_EMIT2;
      end
    end else if (pc < PC_POST) begin
      // lane j += (x += lane j+2) * lane 7-j
      rel = pc - PC_ABSORB;
      j   = rel[4:2];
      unique case (rel[1:0])
        2'd0: begin
          u.rd_a_en   = 1'b1;
          u.rd_a_addr = lane_idx_t'(j + 3'd2);
          u.rd_b_en   = 1'b1;
          u.rd_b_addr = ~j;
        end
        2'd1: begin
          u.x_op      = X_ADD_A;
          u.y_op      = Y_B;
          u.rd_a_en   = 1'b1;
          u.rd_a_addr = j;
        end
        2'd2: begin
          u.mul_start = 1'b1;
          u.y_op      = Y_A;
        end
        2'd3: begin
          u.wait_sel   = W_MUL;
          u.lane_we    = 1'b1;
          u.lane_waddr = j;
          u.mix_we     = (j == 3'd7);
        end
      endcase
    end else if (pc == PC_POST) begin
      u.jmp_sel = J_NO_EOM;
      u.target  = PC_ENTRY;
    end else if (pc == PC_DIG0) begin
      u.x_op    = X_LOAD_MIX;
      u.jmp_sel = J_MODE0;
      u.target  = PC_M0;
    end else if (pc == PC_DIG1) begin
      u.jmp_sel = J_MODE1;
      u.target  = PC_M1;
    end else if (pc == PC_M2) begin
      // 64-bit digest runs the rotate chain on the mix word
      u.x_op      = X_LOAD_MIX;
      u.rd_a_en   = 1'b1;
      u.rd_a_addr = 3'd0;
      u.set_dig   = 1'b1;
      u.jmp_sel   = J_GOTO;
      u.target    = PC_CHAIN;
    end else if (pc < PC_M1) begin
      // word k = mix * lane k + lane k+4
      rel = pc - PC_M0;
      k   = rel[3:2];
      unique case (rel[1:0])
        2'd0: begin
          u.rd_b_en   = 1'b1;
          u.rd_b_addr = {1'b0, k};
        end
        2'd1: begin
          u.y_op      = Y_B;
          u.rd_a_en   = 1'b1;
          u.rd_a_addr = {1'b1, k};
        end
        2'd2: begin
          u.mul_start = 1'b1;
          u.y_op      = Y_A;
        end
        2'd3: begin
          u.wait_sel = W_MUL_OUT;
          u.emit     = 1'b1;
          u.out_num  = k;
          u.out_last = (k == 2'd3);
          if (k == 2'd3) begin
            u.clear   = 1'b1;
            u.jmp_sel = J_GOTO;
            u.target  = PC_ENTRY;
          end
        end
      endcase
    end else if (pc < PC_EMIT2) begin
      // word k = mix * (lane k + lane k+4) + lane k+2 + lane k+6
      rel = pc - PC_M1;
      k   = {1'b0, rel[2]};
      unique case (rel[1:0])
        2'd0: begin
          u.rd_a_en   = 1'b1;
          u.rd_a_addr = {1'b0, k};
          u.rd_b_en   = 1'b1;
          u.rd_b_addr = {1'b1, k};
        end
        2'd1: begin
          u.y_op      = Y_AB;
          u.rd_a_en   = 1'b1;
          u.rd_a_addr = lane_idx_t'({1'b0, k} + 3'd2);
          u.rd_b_en   = 1'b1;
          u.rd_b_addr = lane_idx_t'({1'b0, k} + 3'd6);
        end
        2'd2: begin
          u.mul_start = 1'b1;
          u.y_op      = Y_AB;
        end
        2'd3: begin
          u.wait_sel = W_MUL_OUT;
          u.emit     = 1'b1;
          u.out_num  = k;
          u.out_last = (k == 2'd1);
          if (k == 2'd1) begin
            u.clear   = 1'b1;
            u.jmp_sel = J_GOTO;
            u.target  = PC_ENTRY;
          end
        end
      endcase
    end else if (pc == PC_EMIT2) begin
      u.wait_sel = W_OUT;
      u.emit     = 1'b1;
      u.out_src  = OUT_X;
      u.out_num  = 2'd0;
      u.out_last = 1'b1;
      u.clear    = 1'b1;
      u.jmp_sel  = J_GOTO;
      u.target   = PC_ENTRY;
    end else begin
      u.jmp_sel = J_GOTO;
      u.target  = PC_ENTRY;
    end
    return u;
  endfunction

endpackage

### src/prmh_mul.sv
// iterative 64x64 multiplier, low 64 bits of the product
// one 32x32 partial product per cycle; uses prmh_pkg
module prmh_mul
  import prmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        busy,
  output logic [63:0] prod
);

  localparam logic [2:0] MUL_IDLE = 3'd0;
  localparam logic [2:0] MUL_LL   = 3'd1;
  localparam logic [2:0] MUL_LH   = 3'd2;
  localparam logic [2:0] MUL_HL   = 3'd3;
  localparam logic [2:0] MUL_SUM  = 3'd4;

  logic [2:0]  cnt;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] mprod;
  logic [63:0] pr;
  logic [63:0] acc;

  // operand halves for the current partial product
  always_comb begin
    unique case (cnt)
      MUL_LH: begin
        ma = opa[31:0];
        mb = opb[63:32];
      end
      MUL_HL: begin
        ma = opa[63:32];
        mb = opb[31:0];
      end
      default: begin
        ma = opa[31:0];
        mb = opb[31:0];
      end
    endcase
  end

  // full 64-bit product of the two 32-bit halves
  assign mprod = 64'(ma) * 64'(mb);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= MUL_IDLE;
    end else if (start && cnt == MUL_IDLE) begin
      cnt <= MUL_LL;
    end else if (cnt == MUL_SUM) begin
      cnt <= MUL_IDLE;
    end else if (cnt != MUL_IDLE) begin
      cnt <= cnt + 3'd1;
    end
  end

  // operands, registered partial product, accumulator
  always_ff @(posedge clk) begin
    if (start && cnt == MUL_IDLE) begin
      opa <= a;
      opb <= b;
    end
    pr <= mprod;
    if (cnt == MUL_LH) begin
      acc <= pr;
    end else if (cnt == MUL_HL || cnt == MUL_SUM) begin
      acc <= acc + {pr[31:0], 32'd0};
    end
  end

  assign busy = (cnt != MUL_IDLE);
  assign prod = acc;

endmodule

### src/prmh_dpath.sv
// datapath: lane memory with start-value fallback, mix and temp registers,
// popcount rotate, output register; driven by microcode from prmh_seq, uses prmh_pkg
module prmh_dpath
  import prmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ucode_t      ctrl,
  input  logic        fire,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_kind,
  input  logic [63:0] prod,
  input  logic        out_ready,
  output logic [63:0] mul_a,
  output logic [63:0] mul_b,
  output logic        out_valid,
  output logic [63:0] out_word,
  output logic [1:0]  out_num,
  output logic        out_last
);

  logic [63:0]           lanes [LANE_COUNT];
  logic [LANE_COUNT-1:0] valid;
  logic [63:0]           rda;
  logic [63:0]           rdb;
  logic [63:0]           x;
  logic [63:0]           x_next;
  logic [63:0]           y;
  logic [63:0]           y_next;
  logic [63:0]           mix_word;
  logic [63:0]           r;
  logic [63:0]           in_masked;

  assign r = y + prod;
  assign in_masked = (in_kind == KIND_BYTE) ? {56'd0, in_value[7:0]} : in_value;

  // lane memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (fire && ctrl.lane_we) begin
      lanes[ctrl.lane_waddr] <= r;
    end
    if (fire && ctrl.rd_a_en) begin
      rda <= valid[ctrl.rd_a_addr] ? lanes[ctrl.rd_a_addr] : START_LANES[ctrl.rd_a_addr];
    end
    if (fire && ctrl.rd_b_en) begin
      rdb <= valid[ctrl.rd_b_addr] ? lanes[ctrl.rd_b_addr] : START_LANES[ctrl.rd_b_addr];
    end
  end

  // written marks; a cleared lane reads as its start value
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (fire && ctrl.clear) begin
      valid <= '0;
    end else if (fire && ctrl.lane_we) begin
      valid[ctrl.lane_waddr] <= 1'b1;
    end
  end

  // chain accumulator
  always_comb begin
    unique case (ctrl.x_op)
      X_HOLD:     x_next = x;
      X_LOAD_IN:  x_next = in_masked;
      X_LOAD_MIX: x_next = mix_word;
      X_ADD_A:    x_next = x + rda;
      X_ROT:      x_next = rot_by_ones(x);
      default:    x_next = x;
    endcase
  end

  // multiplier operand and addend
  always_comb begin
    unique case (ctrl.y_op)
      Y_HOLD:  y_next = y;
      Y_A:     y_next = rda;
      Y_B:     y_next = rdb;
      Y_AB:    y_next = rda + rdb;
      default: y_next = y;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      x <= x_next;
      y <= y_next;
    end
  end

  // mix word
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_word <= '0;
    end else if (fire && ctrl.clear) begin
      mix_word <= '0;
    end else if (fire && ctrl.mix_we) begin
      mix_word <= x;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.emit) begin
      out_word <= (ctrl.out_src == OUT_X) ? x : r;
      out_num  <= ctrl.out_num;
      out_last <= ctrl.out_last;
    end
  end

  assign mul_a = x;
  assign mul_b = y;

endmodule

### src/prmh_seq.sv
// microcode sequencer: step counter, control word lookup, waits and jumps
// uses prmh_pkg for the program table and control types
module prmh_seq
  import prmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ucode_t      ctrl,
  output logic        fire,
  output logic        in_ready
);

  pc_t  pc;
  pc_t  pc_next;
  logic dig;
  logic item_no_data;
  logic item_eom;
  logic stall;
  logic take;

  // control word for this step
  always_comb begin
    ctrl = ucode(pc);
  end

  // wait conditions hold the step and suppress its actions
  always_comb begin
    unique case (ctrl.wait_sel)
      W_NONE:    stall = 1'b0;
      W_IN:      stall = !status.in_valid;
      W_MUL:     stall = status.mul_busy;
      W_MUL_OUT: stall = status.mul_busy || status.out_blocked;
      W_OUT:     stall = status.out_blocked;
      default:   stall = 1'b0;
    endcase
  end

  assign fire     = !stall;
  assign in_ready = (ctrl.wait_sel == W_IN);

  // jump conditions
  always_comb begin
    unique case (ctrl.jmp_sel)
      J_NEXT:   take = 1'b0;
      J_GOTO:   take = 1'b1;
      J_NODATA: take = !dig && item_no_data;
      J_NO_EOM: take = !item_eom;
      J_MODE0:  take = status.mode_256;
      J_MODE1:  take = status.mode_128;
      J_DIG:    take = dig;
      default:  take = 1'b0;
    endcase
    if (!fire) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + 7'd1;
    end
  end

  // step counter and item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= PC_ENTRY;
      dig          <= 1'b0;
      item_no_data <= 1'b0;
      item_eom     <= 1'b0;
    end else begin
      pc <= pc_next;
      if (fire && in_ready) begin
        item_no_data <= status.in_no_data;
        item_eom     <= status.in_eom;
      end
      if (fire && ctrl.clear) begin
        dig <= 1'b0;
      end else if (fire && ctrl.set_dig) begin
        dig <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // multiplier is only started when free
  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    fire && ctrl.mul_start |-> !status.mul_busy)
    else $error("multiply started while busy");

  // a digest word is never pushed over a waiting one
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    fire && ctrl.emit |-> !status.out_blocked)
    else $error("output overwritten");

  // the digest chain pass only runs for a closing item
  a_dig_eom: assert property (@(posedge clk) disable iff (rst)
    dig |-> item_eom)
    else $error("digest pass without end of message");

  // no port-A read of a lane in the step that writes it
  a_rw_clash: assert property (@(posedge clk) disable iff (rst)
    fire && ctrl.lane_we && ctrl.rd_a_en |-> ctrl.lane_waddr != ctrl.rd_a_addr)
    else $error("lane read and write collide");
`endif

endmodule

### src/popcount_rotate_multiply_hash_core.sv
// top level of the popcount-rotate-multiply hash core with stream ports and the digest
//   mode register; instantiates prmh_seq, prmh_dpath, prmh_mul, uses prmh_pkg
// data chunk: entry step and rotate chain, then 8 lane updates bound by the multiply;
//   a no-data chunk leaves the chain after its first add and skips the updates;
//   closing adds a 256/128/64-bit digest pass; output stalls hold the emit step;
//   sync reset: start lanes, mix/mode zero
module popcount_rotate_multiply_hash_core
  import prmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // chunk_value
  input  logic [1:0]  s_tuser,   // chunk_kind
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // digest_word [63:0], word_number [65:64], zero fill
  output logic        m_tlast,   // final_word
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data   // digest_mode
);

  logic        [1:0] digest_mode;
  seq_status_t       status;
  ucode_t            ctrl;
  logic              fire;
  logic              mul_busy;
  logic [63:0]       prod;
  logic [63:0]       mul_a;
  logic [63:0]       mul_b;
  logic [63:0]       out_word;
  logic [1:0]        out_num;

  // mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_mode <= MODE_256;
    end else if (cfg_valid) begin
      digest_mode <= cfg_data;
    end
  end

  // sequencer status
  always_comb begin
    status.in_valid    = s_tvalid;
    status.in_no_data  = (s_tuser != KIND_WORD) && (s_tuser != KIND_BYTE);
    status.in_eom      = s_tlast;
    status.mul_busy    = mul_busy;
    status.out_blocked = m_tvalid && !m_tready;
    status.mode_256    = (digest_mode == MODE_256);
    status.mode_128    = (digest_mode == MODE_128);
  end

  prmh_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .ctrl     (ctrl),
    .fire     (fire),
    .in_ready (s_tready)
  );

  prmh_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .fire      (fire),
    .in_value  (s_tdata),
    .in_kind   (s_tuser),
    .prod      (prod),
    .out_ready (m_tready),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .out_valid (m_tvalid),
    .out_word  (out_word),
    .out_num   (out_num),
    .out_last  (m_tlast)
  );

  prmh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (fire && ctrl.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  assign m_tdata = {6'd0, out_num, out_word};

endmodule
